// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, held off while reset is asserted.
`define MRC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check on a plain clock with no reset gating.
`define MRC_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mrc_pkg.sv =====
// Shared types and constants of the mixed radix converter.
package mrc_pkg;

	localparam int unsigned POSITIONS = 4;

	// Command codes carried by an input transaction.
	localparam logic [1:0] CMD_EVAL     = 2'd0;
	localparam logic [1:0] CMD_DIGITIZE = 2'd1;
	localparam logic [1:0] CMD_STEP     = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_COUNT      = 3'd0;
	localparam logic [2:0] REG_BASE_ZERO  = 3'd1;
	localparam logic [2:0] REG_BASE_ONE   = 3'd2;
	localparam logic [2:0] REG_BASE_TWO   = 3'd3;
	localparam logic [2:0] REG_BASE_THREE = 3'd4;

	localparam logic [2:0]  COUNT_RESET = 3'd4;
	localparam logic [15:0] BASE_RESET  = 16'd10;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP,
		S_DIV,
		S_POST,
		S_MUL_D,
		S_MUL_B,
		S_NEXT,
		S_MUL_O,
		S_ADD_O,
		S_DONE
	} state_t;

endpackage

// ===== hdl/mixed_radix_converter.sv =====
// Mixed radix converter: evaluate, digitize and step over up to four digits.
// Input channel src_valid/src_stall carries one command with its digits,
// value, position, amount and carry mode. The block stalls the source while
// it works on a transaction; the result appears on res_valid/res_stall.
// All divisions go through one bit-serial divider that retires one quotient
// bit a cycle, and one 32x18 multiplier serves the evaluate command.
// States from acceptance to result valid:
//   evaluate: SETUP, DIV, POST, MUL_D, MUL_B and NEXT per active digit,
//             then MUL_O, ADD_O and DONE
//   digitize: SETUP, DIV and POST per active digit, then DONE
//   step:     SETUP, DIV and POST per digit the carry visits, then DONE;
//             a zero amount or an unused position goes straight to DONE
//   unused command: straight to DONE
// A new transaction can be taken in the cycle after the result loads, even
// while that result waits under res_stall in the result register; a
// finished transaction holds in its last state until the register is free.
// Configuration writes (wr_en, wr_index, wr_data) take effect at once; the
// user makes them only while the block is idle (the block does not enforce
// this). Reset sets four digits of base ten and empties the result register.
module mixed_radix_converter #(
	parameter int unsigned MAX_DIGITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [15:0]        wr_data,
	input  logic               src_valid,
	output logic               src_stall,
	input  logic [1:0]         command,
	input  logic [15:0]        digit_in_zero,
	input  logic [15:0]        digit_in_one,
	input  logic [15:0]        digit_in_two,
	input  logic [15:0]        digit_in_three,
	input  logic [31:0]        value_in,
	input  logic [1:0]         position,
	input  logic signed [15:0] amount,
	input  logic               carry_mode,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [31:0]        value_out,
	output logic [15:0]        digit_out_zero,
	output logic [15:0]        digit_out_one,
	output logic [15:0]        digit_out_two,
	output logic [15:0]        digit_out_three,
	output logic               in_range
);

	localparam logic [2:0] MAX_N = (MAX_DIGITS < mrc_pkg::POSITIONS) ?
		3'(MAX_DIGITS) : 3'(mrc_pkg::POSITIONS);

	mrc_pkg::state_t state_q, state_nx;

	logic [2:0]         count_q;
	logic [15:0]        base_q [mrc_pkg::POSITIONS];
	logic [1:0]         cmd_q;
	logic               carry_q;
	logic [15:0]        dig_q  [mrc_pkg::POSITIONS];
	logic [15:0]        res_q  [mrc_pkg::POSITIONS];
	logic [1:0]         idx_q;
	logic [2:0]         n_q;
	logic [31:0]        val_q;
	logic [31:0]        factor_q;
	logic [31:0]        prod_q;
	logic [31:0]        work_q;
	logic [17:0]        over_q;
	logic signed [19:0] amt_q;
	logic               neg_q;
	logic               ok_q;
	logic [31:0]        quo_q;
	logic [15:0]        rem_q;
	logic [4:0]         cnt_q;
	logic               res_valid_q;

	logic        src_take;
	logic        out_free;
	logic [2:0]  n_eff;
	logic [15:0] base_eff;
	logic        last_pos;
	logic [16:0] rem_sh;
	logic        rem_ge;
	logic [16:0] rem_sub;
	logic [18:0] eval_sum;
	logic signed [20:0] step_x;
	logic [20:0] step_mag;
	logic        rem_nz;
	logic [15:0] r_floor;
	logic [19:0] q_inc;
	logic [19:0] q_floor;
	logic [17:0] mul_b;
	logic [49:0] mul_full;

	assign src_stall = (state_q != mrc_pkg::S_IDLE);
	assign src_take  = src_valid && !src_stall;
	assign res_valid = res_valid_q;
	assign out_free  = !res_valid_q || !res_stall;

	// Clamp the digit count to the supported range.
	always_comb begin
		n_eff = count_q;
		if (n_eff == 3'd0) n_eff = 3'd1;
		if (n_eff > MAX_N) n_eff = MAX_N;
	end

	assign base_eff = (base_q[idx_q] == 16'd0) ? 16'd1 : base_q[idx_q];
	assign last_pos = ({1'b0, idx_q} == (n_q - 3'd1));

	// Divider step: shift in one dividend bit, subtract when it fits.
	assign rem_sh  = {rem_q, quo_q[31]};
	assign rem_ge  = (rem_sh >= {1'b0, base_eff});
	assign rem_sub = rem_sh - {1'b0, base_eff};

	// Dividends for evaluate and step.
	assign eval_sum = {3'b000, dig_q[idx_q]} + {1'b0, over_q};
	assign step_x   = $signed({5'b00000, dig_q[idx_q]}) + $signed({amt_q[19], amt_q});
	assign step_mag = step_x[20] ? 21'(-step_x) : 21'(step_x);

	// Floored quotient and remainder for step.
	assign rem_nz  = (rem_q != 16'd0);
	assign r_floor = (neg_q && rem_nz) ? (base_eff - rem_q) : rem_q;
	assign q_inc   = quo_q[19:0] + {19'd0, neg_q && rem_nz};
	assign q_floor = neg_q ? (20'd0 - q_inc) : q_inc;

	// Shared multiplier operand select.
	always_comb begin
		case (state_q)
			mrc_pkg::S_MUL_D: mul_b = {2'b00, res_q[idx_q]};
			mrc_pkg::S_MUL_B: mul_b = {2'b00, base_eff};
			default:          mul_b = over_q;
		endcase
	end
	assign mul_full = factor_q * mul_b;

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mrc_pkg::S_IDLE: begin
				if (src_take) begin
					if (command == mrc_pkg::CMD_EVAL || command == mrc_pkg::CMD_DIGITIZE)
						state_nx = mrc_pkg::S_SETUP;
					else if (command == mrc_pkg::CMD_STEP && amount != 16'sd0
						&& {1'b0, position} < n_eff)
						state_nx = mrc_pkg::S_SETUP;
					else
						state_nx = mrc_pkg::S_DONE;
				end
			end
			mrc_pkg::S_SETUP: state_nx = mrc_pkg::S_DIV;
			mrc_pkg::S_DIV: begin
				if (cnt_q == 5'd31) state_nx = mrc_pkg::S_POST;
			end
			mrc_pkg::S_POST: begin
				case (cmd_q)
					mrc_pkg::CMD_EVAL: state_nx = mrc_pkg::S_MUL_D;
					mrc_pkg::CMD_DIGITIZE:
						state_nx = last_pos ? mrc_pkg::S_DONE : mrc_pkg::S_SETUP;
					default: begin
						if (q_floor == 20'd0 || !carry_q || last_pos)
							state_nx = mrc_pkg::S_DONE;
						else
							state_nx = mrc_pkg::S_SETUP;
					end
				endcase
			end
			mrc_pkg::S_MUL_D: state_nx = mrc_pkg::S_MUL_B;
			mrc_pkg::S_MUL_B: state_nx = mrc_pkg::S_NEXT;
			mrc_pkg::S_NEXT:  state_nx = last_pos ? mrc_pkg::S_MUL_O : mrc_pkg::S_SETUP;
			mrc_pkg::S_MUL_O: state_nx = mrc_pkg::S_ADD_O;
			mrc_pkg::S_ADD_O: state_nx = mrc_pkg::S_DONE;
			mrc_pkg::S_DONE: begin
				if (out_free) state_nx = mrc_pkg::S_IDLE;
			end
			default: state_nx = mrc_pkg::S_IDLE;
		endcase
	end

	// Control registers: state, configuration, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mrc_pkg::S_IDLE;
			res_valid_q <= 1'b0;
			count_q     <= mrc_pkg::COUNT_RESET;
			for (int i = 0; i < mrc_pkg::POSITIONS; i++) base_q[i] <= mrc_pkg::BASE_RESET;
		end else begin
			state_q <= state_nx;
			if (state_q == mrc_pkg::S_DONE && out_free)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
			if (wr_en) begin
				unique case (wr_index)
					mrc_pkg::REG_COUNT:      count_q   <= wr_data[2:0];
					mrc_pkg::REG_BASE_ZERO:  base_q[0] <= wr_data;
					mrc_pkg::REG_BASE_ONE:   base_q[1] <= wr_data;
					mrc_pkg::REG_BASE_TWO:   base_q[2] <= wr_data;
					mrc_pkg::REG_BASE_THREE: base_q[3] <= wr_data;
					default: ;
				endcase
			end
		end
	end

	// Datapath: operands, divider, multiplier accumulation, result register.
	always_ff @(posedge clk) begin
		case (state_q)
			mrc_pkg::S_IDLE: begin
				if (src_take) begin
					cmd_q    <= command;
					carry_q  <= carry_mode;
					dig_q[0] <= digit_in_zero;
					dig_q[1] <= digit_in_one;
					dig_q[2] <= digit_in_two;
					dig_q[3] <= digit_in_three;
					for (int i = 0; i < mrc_pkg::POSITIONS; i++) res_q[i] <= 16'd0;
					n_q      <= n_eff;
					idx_q    <= (command == mrc_pkg::CMD_STEP) ? position : 2'd0;
					val_q    <= (command == mrc_pkg::CMD_DIGITIZE) ? value_in : 32'd0;
					work_q   <= value_in;
					factor_q <= 32'd1;
					over_q   <= 18'd0;
					amt_q    <= 20'(amount);
					ok_q     <= !(command == mrc_pkg::CMD_STEP && amount != 16'sd0);
				end
			end
			mrc_pkg::S_SETUP: begin
				rem_q <= 16'd0;
				cnt_q <= 5'd0;
				case (cmd_q)
					mrc_pkg::CMD_EVAL:     quo_q <= {13'd0, eval_sum};
					mrc_pkg::CMD_DIGITIZE: quo_q <= work_q;
					default: begin
						quo_q <= {11'd0, step_mag};
						neg_q <= step_x[20];
					end
				endcase
			end
			mrc_pkg::S_DIV: begin
				rem_q <= rem_ge ? rem_sub[15:0] : rem_sh[15:0];
				quo_q <= {quo_q[30:0], rem_ge};
				cnt_q <= cnt_q + 5'd1;
			end
			mrc_pkg::S_POST: begin
				case (cmd_q)
					mrc_pkg::CMD_EVAL: begin
						res_q[idx_q] <= rem_q;
						over_q       <= carry_q ? quo_q[17:0] : 18'd0;
					end
					mrc_pkg::CMD_DIGITIZE: begin
						res_q[idx_q] <= rem_q;
						work_q       <= quo_q;
						if (!last_pos) idx_q <= idx_q + 2'd1;
					end
					default: begin
						dig_q[idx_q] <= r_floor;
						amt_q        <= q_floor;
						ok_q         <= (q_floor == 20'd0);
						if (!last_pos) idx_q <= idx_q + 2'd1;
					end
				endcase
			end
			mrc_pkg::S_MUL_D: prod_q <= mul_full[31:0];
			mrc_pkg::S_MUL_B: begin
				val_q  <= val_q + prod_q;
				prod_q <= mul_full[31:0];
			end
			mrc_pkg::S_NEXT: begin
				factor_q <= prod_q;
				if (!last_pos) idx_q <= idx_q + 2'd1;
			end
			mrc_pkg::S_MUL_O: prod_q <= mul_full[31:0];
			mrc_pkg::S_ADD_O: val_q  <= val_q + prod_q;
			mrc_pkg::S_DONE: begin
				if (out_free) begin
					value_out <= val_q;
					in_range  <= ok_q;
					if (cmd_q == mrc_pkg::CMD_STEP) begin
						digit_out_zero  <= dig_q[0];
						digit_out_one   <= (n_q > 3'd1) ? dig_q[1] : 16'd0;
						digit_out_two   <= (n_q > 3'd2) ? dig_q[2] : 16'd0;
						digit_out_three <= (n_q > 3'd3) ? dig_q[3] : 16'd0;
					end else begin
						digit_out_zero  <= res_q[0];
						digit_out_one   <= res_q[1];
						digit_out_two   <= res_q[2];
						digit_out_three <= res_q[3];
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/mrc_checker.sv =====
// Port-level checks of the mixed radix converter, bound to the top level.
`include "assert_macros.svh"

module mrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        src_valid,
	input logic        src_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [31:0] value_out,
	input logic        in_range
);

	// Hold a stalled result.
	`MRC_ASSERT(a_res_hold, clk, arst_n, res_valid && res_stall |=> res_valid, "result dropped under stall")

	// Block further input right after a transaction is taken.
	`MRC_ASSERT(a_busy_after_take, clk, arst_n, src_valid && !src_stall |=> src_stall, "input taken while busy")

	// Only a step reports out of range, and a step returns a zero value.
	`MRC_ASSERT(a_range_value, clk, arst_n, res_valid && !in_range |-> value_out == 32'd0, "out-of-range result with value")

endmodule

bind mixed_radix_converter mrc_checker u_mrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.value_out (value_out),
	.in_range  (in_range)
);
